FILE: hw/rtl/drwc_pkg.sv
// ----------------------------------------------------------------------------
// drwc_pkg
// types, codes and value tables shared by the register write coalescer
// ----------------------------------------------------------------------------
`default_nettype none

package drwc_pkg;

   localparam int VALUE_COUNT = 18;
   localparam int IDX_W       = 5;
   localparam int VALUE_W     = 32;
   localparam int BUS_W       = 16;
   localparam int STATUS_W    = 3;
   localparam int MODE_W      = 3;
   localparam int POS_W       = 3;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   // item modes
   localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_DRAIN   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_RESET   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_PROFILE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_READ    = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_IDX  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DISABLED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTHING  = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FORCE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOAD_UPD  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_CNT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BUS_BASE  = 3'd4;

   // special value numbers
   localparam logic [IDX_W-1:0] IDX_FTW0    = 5'd6;
   localparam logic [IDX_W-1:0] IDX_FTW1    = 5'd8;
   localparam logic [IDX_W-1:0] IDX_FTW2    = 5'd10;
   localparam logic [IDX_W-1:0] IDX_FTW3    = 5'd12;
   localparam logic [IDX_W-1:0] IDX_CTRL    = 5'd14;
   localparam logic [IDX_W-1:0] IDX_MRESET  = 5'd15;
   localparam logic [IDX_W-1:0] IDX_LOAD    = 5'd16;
   localparam logic [IDX_W-1:0] IDX_SPARE   = 5'd17;

   localparam logic [VALUE_W-1:0] SHADOW0_RESET  = 32'h0000_0018;
   localparam logic [7:0]         PROFILE1_ADD   = 8'h80;
   localparam logic [7:0]         PROFILE0_ADD   = 8'h40;
   localparam logic [POS_W-1:0]   FREQ_CNT_RESET = 3'd4;
   localparam logic [POS_W-1:0]   FREQ_CNT_MAX   = 3'd4;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                bus_valid;
      logic [BUS_W-1:0]    bus_address;
      logic [BUS_W-1:0]    bus_data;
      logic [VALUE_W-1:0]  read_value;
      logic                last;
   } result_type;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_EVAL  = 5'b00010,
      S_FETCH = 5'b00100,
      S_LOAD  = 5'b01000,
      S_SEND  = 5'b10000
   } state_type;

   // bytes held by each value
   function automatic logic [POS_W-1:0] value_len(input logic [IDX_W-1:0] idx);
      logic [POS_W-1:0] len;
      case (idx)
         5'd4, 5'd6, 5'd8, 5'd10, 5'd12: len = 3'd4;
         5'd5, 5'd7, 5'd9, 5'd11, 5'd13: len = 3'd2;
         default:                        len = 3'd1;
      endcase
      return len;
   endfunction

   // chip register address of each value
   function automatic logic [7:0] value_reg(input logic [IDX_W-1:0] idx);
      logic [7:0] r;
      case (idx)
         5'd0:    r = 8'h00;
         5'd1:    r = 8'h01;
         5'd2:    r = 8'h02;
         5'd3:    r = 8'h03;
         5'd4:    r = 8'h04;
         5'd5:    r = 8'h08;
         5'd6:    r = 8'h0A;
         5'd7:    r = 8'h0E;
         5'd8:    r = 8'h10;
         5'd9:    r = 8'h14;
         5'd10:   r = 8'h16;
         5'd11:   r = 8'h1A;
         5'd12:   r = 8'h1C;
         5'd13:   r = 8'h20;
         5'd14:   r = 8'h30;
         5'd15:   r = 8'h31;
         5'd16:   r = 8'h32;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [VALUE_W-1:0] shadow_reset(input logic [IDX_W-1:0] idx);
      return (idx == '0) ? SHADOW0_RESET : '0;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/drwc_ram.sv
// ----------------------------------------------------------------------------
// drwc_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module drwc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 18
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

FILE: hw/rtl/dds_register_write_coalescer.sv
// ----------------------------------------------------------------------------
// dds_register_write_coalescer
// shadow values and index queue in front of a byte wide synthesizer bus
// ----------------------------------------------------------------------------
// output: a result word is registered and is on rsp in the cycle after the evaluation or send cycle that builds it
// sequence: write, read, reset and profile items go eval then idle; a drain
//   continuing a value adds send, a drain that starts a value adds fetch, load
//   and send for the chained queue read then shadow read; one item at a time
// reset: synchronous, clears control state and queue pointers; shadow entries
//   read their reset value until written, no clearing pass is needed
// ----------------------------------------------------------------------------
`default_nettype none

module dds_register_write_coalescer
   import drwc_pkg::*;
#(
   parameter int QUEUE_DEPTH = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // value_index[4:0], new_value[36:5], profile_which[37], profile_level[38], zero
   input  wire logic [39:0]           req_tdata,
   // mode[2:0]
   input  wire logic [MODE_W-1:0]     req_tuser,
   // response stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // bus_address[15:0], bus_data[31:16], read_value[63:32]
   output logic [63:0]                rsp_tdata,
   // status[2:0], bus_valid[3]
   output logic [3:0]                 rsp_tuser,
   output logic                       rsp_tlast,
   // register write port
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // request field split
   logic [IDX_W-1:0]   req_idx;
   logic [VALUE_W-1:0] req_val;
   logic               req_which;
   logic               req_level;
   logic               req_fire;
   logic               rsp_fire;

   assign req_idx   = req_tdata[4:0];
   assign req_val   = req_tdata[36:5];
   assign req_which = req_tdata[37];
   assign req_level = req_tdata[38];

   // control state
   state_type        state_ff, state_in;
   logic             en_ff, en_in;
   logic             force_ff, force_in;
   logic             lwu_ff, lwu_in;
   logic [POS_W-1:0] fbc_ff, fbc_in;
   logic [BUS_W-1:0] base_ff, base_in;

   logic [VALUE_COUNT-1:0] valid_ff, valid_in;     // shadow entry written since reset
   logic [VALUE_COUNT-1:0] queued_ff, queued_in;   // index is waiting in the queue
   logic [PTR_W-1:0]       head_ff, head_in;
   logic [PTR_W-1:0]       tail_ff, tail_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   logic               active_ff, active_in;
   logic [IDX_W-1:0]   send_idx_ff, send_idx_in;
   logic [VALUE_W-1:0] send_val_ff, send_val_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [1:0]         profile_ff, profile_in;

   // captured item (payload)
   logic [MODE_W-1:0]  item_mode_ff;
   logic [IDX_W-1:0]   item_idx_ff;
   logic [VALUE_W-1:0] item_val_ff;
   logic               item_which_ff;
   logic               item_level_ff;
   logic [IDX_W-1:0]   fetch_idx_ff, fetch_idx_in;

   // output buffer, two words deep for the load plus update pair
   result_type out0_ff, out1_ff;
   logic       out0_valid_ff, out1_valid_ff;
   result_type res0, res1;
   logic       load_out;
   logic       load_two;

   // memories
   logic               sh_we;
   logic [IDX_W-1:0]   sh_raddr;
   logic [VALUE_W-1:0] sh_rdata;
   logic               q_we;
   logic [PTR_W-1:0]   q_waddr;
   logic [IDX_W-1:0]   q_wdata;
   logic [IDX_W-1:0]   q_rdata;

   // derived values
   logic               item_in_range;
   logic [IDX_W-1:0]   item_sidx;
   logic [IDX_W-1:0]   req_sidx;
   logic [IDX_W-1:0]   rd_sel;
   logic [VALUE_W-1:0] shadow_q;
   logic [IDX_W-1:0]   q_idx;
   logic               q_full;
   logic [PTR_W-1:0]   tail_next;
   logic [PTR_W-1:0]   head_next;
   logic               changed;

   // start position for a new value
   logic [POS_W-1:0] fetch_len;
   logic [POS_W-1:0] fetch_prec;
   logic [POS_W-1:0] fetch_start;
   logic             fetch_is_ftw;

   // byte formatting for the value being sent
   logic [POS_W-1:0] send_len;
   logic [1:0]       send_sub;
   logic [POS_W-1:0] send_pos_next;
   logic [7:0]       send_reg;
   logic [7:0]       send_byte;
   logic [BUS_W-1:0] send_addr;
   logic [BUS_W-1:0] send_off;
   logic             send_final;
   logic             send_pseudo;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   assign item_in_range = (item_idx_ff < IDX_W'(VALUE_COUNT));
   assign item_sidx     = item_in_range ? item_idx_ff : '0;
   assign req_sidx      = (req_idx < IDX_W'(VALUE_COUNT)) ? req_idx : '0;

   // shadow read data, entries never written read as their reset value
   assign rd_sel   = (state_ff == S_LOAD) ? fetch_idx_ff : item_sidx;
   assign shadow_q = valid_ff[rd_sel] ? sh_rdata : shadow_reset(rd_sel);

   assign q_idx     = (q_rdata >= IDX_W'(VALUE_COUNT)) ? q_rdata - IDX_W'(VALUE_COUNT)
                                                      : q_rdata;
   assign q_full    = (count_ff >= CNT_W'(QUEUE_DEPTH));
   assign tail_next = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
   assign head_next = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign changed   = (shadow_q != item_val_ff) || force_ff;

   // frequency words send only the top fbc bytes, with fbc clamped to 1..FREQ_CNT_MAX
   always_comb begin
      fetch_len    = value_len(fetch_idx_ff);
      fetch_is_ftw = (fetch_idx_ff == IDX_FTW0) || (fetch_idx_ff == IDX_FTW1) ||
                     (fetch_idx_ff == IDX_FTW2) || (fetch_idx_ff == IDX_FTW3);
      fetch_prec   = fetch_len;
      if (fetch_is_ftw) begin
         if (fbc_ff == '0) begin
            fetch_prec = 3'd1;
         end else if (fbc_ff > FREQ_CNT_MAX) begin
            fetch_prec = FREQ_CNT_MAX;
         end else begin
            fetch_prec = fbc_ff;
         end
      end
      fetch_start = (fetch_len > fetch_prec) ? fetch_len - fetch_prec : '0;
   end

   // bus word for the current byte
   always_comb begin
      send_len      = value_len(send_idx_ff);
      send_sub      = pos_ff[1:0];
      send_pos_next = pos_ff + 1'b1;
      send_final    = (send_pos_next >= send_len);
      send_pseudo   = (send_idx_ff == IDX_MRESET) || (send_idx_ff == IDX_LOAD) ||
                      (send_idx_ff == IDX_SPARE);
      case (send_idx_ff)
         IDX_CTRL:           send_off = BUS_W'(2);
         IDX_LOAD, IDX_SPARE: send_off = BUS_W'(3);
         IDX_MRESET:         send_off = BUS_W'(0);
         default:            send_off = BUS_W'(1);
      endcase
      send_addr = base_ff + send_off;
      send_reg  = value_reg(send_idx_ff) + {6'd0, send_sub};
      if (profile_ff[1]) begin
         send_reg = send_reg + PROFILE1_ADD;
      end
      if (profile_ff[0]) begin
         send_reg = send_reg + PROFILE0_ADD;
      end
      send_byte = send_val_ff[{send_sub, 3'b000} +: 8];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      en_in        = en_ff;
      force_in     = force_ff;
      lwu_in       = lwu_ff;
      fbc_in       = fbc_ff;
      base_in      = base_ff;
      valid_in     = valid_ff;
      queued_in    = queued_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      active_in    = active_ff;
      send_idx_in  = send_idx_ff;
      send_val_in  = send_val_ff;
      pos_in       = pos_ff;
      profile_in   = profile_ff;
      fetch_idx_in = fetch_idx_ff;

      sh_we    = 1'b0;
      sh_raddr = item_sidx;
      q_we     = 1'b0;
      q_waddr  = tail_ff;
      q_wdata  = item_sidx;

      res0     = '0;
      res1     = '0;
      load_out = 1'b0;
      load_two = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               sh_raddr = req_sidx;
               state_in = S_EVAL;
            end
         end

         // read data for the item is here, wait for a free output buffer
         S_EVAL: begin
            if (!out0_valid_ff) begin
               load_out    = 1'b1;
               res0.last   = 1'b1;
               res0.status = ST_OK;
               state_in    = S_IDLE;
               if (!en_ff) begin
                  res0.status = ST_DISABLED;
               end else begin
                  case (item_mode_ff)
                     MODE_WRITE: begin
                        if (!item_in_range) begin
                           res0.status = ST_BAD_IDX;
                        end else if (changed) begin
                           if (q_full) begin
                              res0.status = ST_FULL;
                           end else begin
                              sh_we               = 1'b1;
                              valid_in[item_sidx] = 1'b1;
                              if (!queued_ff[item_sidx]) begin
                                 q_we                 = 1'b1;
                                 q_wdata              = item_sidx;
                                 tail_in              = tail_next;
                                 count_in             = count_ff + 1'b1;
                                 queued_in[item_sidx] = 1'b1;
                              end
                           end
                        end
                     end
                     MODE_READ: begin
                        if (!item_in_range) begin
                           res0.status = ST_BAD_IDX;
                        end else begin
                           res0.read_value = shadow_q;
                        end
                     end
                     MODE_DRAIN: begin
                        if (active_ff) begin
                           load_out = 1'b0;
                           state_in = S_SEND;
                        end else if (count_ff == '0) begin
                           res0.status = ST_NOTHING;
                        end else begin
                           load_out         = 1'b0;
                           fetch_idx_in     = q_idx;
                           queued_in[q_idx] = 1'b0;
                           head_in          = head_next;
                           count_in         = count_ff - 1'b1;
                           state_in         = S_FETCH;
                        end
                     end
                     MODE_RESET: begin
                        if (q_full) begin
                           res0.status = ST_FULL;
                        end else begin
                           valid_in    = '0;
                           queued_in   = '0;
                           head_in     = '0;
                           tail_in     = PTR_W'(1);
                           count_in    = CNT_W'(1);
                           q_we        = 1'b1;
                           q_waddr     = '0;
                           q_wdata     = IDX_MRESET;
                           active_in   = 1'b0;
                           send_idx_in = '0;
                           send_val_in = '0;
                           pos_in      = '0;
                           profile_in  = '0;
                           fbc_in      = FREQ_CNT_RESET;
                        end
                     end
                     MODE_PROFILE: begin
                        profile_in[item_which_ff] = item_level_ff;
                        if (q_full) begin
                           res0.status = ST_FULL;
                        end else begin
                           q_we     = 1'b1;
                           q_wdata  = IDX_LOAD;
                           tail_in  = tail_next;
                           count_in = count_ff + 1'b1;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end

         S_FETCH: begin
            sh_raddr = fetch_idx_ff;
            state_in = S_LOAD;
         end

         S_LOAD: begin
            active_in   = 1'b1;
            send_idx_in = fetch_idx_ff;
            send_val_in = shadow_q;
            pos_in      = fetch_start;
            state_in    = S_SEND;
         end

         S_SEND: begin
            if (!out0_valid_ff) begin
               load_out              = 1'b1;
               state_in              = S_IDLE;
               res0.status           = ST_OK;
               res0.bus_valid        = 1'b1;
               res0.bus_data         = {send_byte, send_reg};
               res0.bus_address      = send_addr;
               res0.last             = 1'b1;
               if (send_final) begin
                  active_in = 1'b0;
                  pos_in    = '0;
                  if (!send_pseudo) begin
                     // update strobe goes one address up
                     if (!lwu_ff) begin
                        load_two         = 1'b1;
                        res0.last        = 1'b0;
                        res1             = res0;
                        res1.last        = 1'b1;
                        res1.bus_address = send_addr + 1'b1;
                     end else begin
                        res0.bus_address = send_addr + 1'b1;
                     end
                  end
               end else begin
                  pos_in = send_pos_next;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // register writes must arrive only while idle; the block itself does not enforce this
      if (csr_we) begin
         unique case (csr_index)
            CSR_ENABLE:   en_in    = csr_wdata[0];
            CSR_FORCE:    force_in = csr_wdata[0];
            CSR_LOAD_UPD: lwu_in   = csr_wdata[0];
            CSR_FREQ_CNT: fbc_in   = csr_wdata[POS_W-1:0];
            CSR_BUS_BASE: base_in  = csr_wdata[BUS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         en_ff         <= 1'b1;
         force_ff      <= 1'b0;
         lwu_ff        <= 1'b0;
         fbc_ff        <= FREQ_CNT_RESET;
         base_ff       <= '0;
         valid_ff      <= '0;
         queued_ff     <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         active_ff     <= 1'b0;
         send_idx_ff   <= '0;
         send_val_ff   <= '0;
         pos_ff        <= '0;
         profile_ff    <= '0;
         out0_valid_ff <= 1'b0;
         out1_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         en_ff       <= en_in;
         force_ff    <= force_in;
         lwu_ff      <= lwu_in;
         fbc_ff      <= fbc_in;
         base_ff     <= base_in;
         valid_ff    <= valid_in;
         queued_ff   <= queued_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
         active_ff   <= active_in;
         send_idx_ff <= send_idx_in;
         send_val_ff <= send_val_in;
         pos_ff      <= pos_in;
         profile_ff  <= profile_in;
         if (load_out) begin
            out0_valid_ff <= 1'b1;
            out1_valid_ff <= load_two;
         end else if (rsp_fire) begin
            out0_valid_ff <= out1_valid_ff;
            out1_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_mode_ff  <= req_tuser;
         item_idx_ff   <= req_idx;
         item_val_ff   <= req_val;
         item_which_ff <= req_which;
         item_level_ff <= req_level;
      end
      fetch_idx_ff <= fetch_idx_in;
      if (load_out) begin
         out0_ff <= res0;
         out1_ff <= res1;
      end else if (rsp_fire) begin
         out0_ff <= out1_ff;
      end
   end

   // shadow values
   drwc_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (VALUE_COUNT)
   ) u_shadow_ram (
      .clock (clock),
      .we    (sh_we),
      .waddr (item_sidx),
      .wdata (item_val_ff),
      .raddr (sh_raddr),
      .rdata (sh_rdata)
   );

   // index queue, read at the head
   drwc_ram #(
      .WIDTH (IDX_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock (clock),
      .we    (q_we),
      .waddr (q_waddr),
      .wdata (q_wdata),
      .raddr (head_ff),
      .rdata (q_rdata)
   );

   assign rsp_tvalid = out0_valid_ff;
   assign rsp_tdata  = {out0_ff.read_value, out0_ff.bus_data, out0_ff.bus_address};
   assign rsp_tuser  = {out0_ff.bus_valid, out0_ff.status};
   assign rsp_tlast  = out0_ff.last;

endmodule

`default_nettype wire
